>>> hdl/xtppi_pkg.sv
`default_nettype none

package xtppi_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FAULT = 2'd2,
        CMD_KEY   = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
    localparam logic [1:0] ST_CTRL_READ = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    localparam logic [1:0] CFG_BASE_PORT = 2'd0;
    localparam logic [1:0] CFG_DIP_LOW   = 2'd1;
    localparam logic [1:0] CFG_DIP_HIGH  = 2'd2;

    localparam logic [15:0] BASE_PORT_RESET = 16'h0060;
    localparam logic [7:0]  MODE_RESET      = 8'h9b;

    localparam logic [7:0] MODE_NOT_ZERO = 8'h64;
    localparam logic [7:0] MODE_FLAG     = 8'h80;
    localparam logic [7:0] B_CLK_ENABLE  = 8'h40;
    localparam logic [7:0] B_KBD_CLEAR   = 8'h80;
    localparam logic [7:0] B_NO_IOCHK    = 8'h20;
    localparam logic [7:0] B_NO_PARITY   = 8'h10;
    localparam logic [7:0] C_IOCHK       = 8'h40;
    localparam logic [7:0] C_PARITY      = 8'h80;
    localparam logic [7:0] NIBBLE_LOW    = 8'h0f;
    localparam logic [7:0] NIBBLE_HIGH   = 8'hf0;

    typedef struct packed {
        logic [15:0] base_port;
        logic [3:0]  dip_low;
        logic [3:0]  dip_high;
    } cfg_t;

    typedef struct packed {
        logic [7:0] mode_word;
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
        logic [7:0] held_key;
        logic       key_ready;
        logic       io_check_level;
        logic       parity_level;
        logic       nmi_sent;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode_word:      MODE_RESET,
        latch_a:        8'h00,
        latch_b:        8'h00,
        latch_c:        8'h00,
        held_key:       8'h00,
        key_ready:      1'b0,
        io_check_level: 1'b0,
        parity_level:   1'b0,
        nmi_sent:       1'b0
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        fault_select;
        logic        fault_level;
        logic [7:0]  key_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       irq_level;
        logic       nmi_pulse;
        logic       speaker_gate;
        logic       speaker_enable;
        logic       kbd_clock_held;
        logic       kbd_clear;
        logic       key_dropped;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/xtppi_in_if.sv
`default_nettype none

interface xtppi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        fault_select;
    logic        fault_level;
    logic [7:0]  key_byte;

    modport source (
        output valid, command, address, write_data, fault_select, fault_level, key_byte,
        input  ready
    );
    modport sink (
        input  valid, command, address, write_data, fault_select, fault_level, key_byte,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/xtppi_out_if.sv
`default_nettype none

interface xtppi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       irq_level;
    logic       nmi_pulse;
    logic       speaker_gate;
    logic       speaker_enable;
    logic       kbd_clock_held;
    logic       kbd_clear;
    logic       key_dropped;

    modport source (
        output valid, read_data, status, irq_level, nmi_pulse, speaker_gate,
               speaker_enable, kbd_clock_held, kbd_clear, key_dropped,
        input  ready
    );
    modport sink (
        input  valid, read_data, status, irq_level, nmi_pulse, speaker_gate,
               speaker_enable, kbd_clock_held, kbd_clear, key_dropped,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/xtppi_step.sv
`default_nettype none

module xtppi_step
    import xtppi_pkg::*;
(
    input  wire cfg_t     cfg,
    input  wire state_t   cur,
    input  wire in_item_t item,
    output state_t        nxt,
    output out_item_t     res
);

    logic        in_mode0;
    logic        a_is_input;
    logic        b_is_output;
    logic [7:0]  c_view;
    logic [3:0]  switch_nibble;
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] pc;
    logic [15:0] pk;
    logic [7:0]  bit_mask;
    logic        do_refresh;
    logic        nxt_b_out;
    logic        pending;
    logic        kbd_enabled;
    logic [7:0]  rdata;
    logic [1:0]  status;
    logic        released;
    logic        nmi;
    state_t      upd;

    assign in_mode0    = (cur.mode_word & MODE_NOT_ZERO) == 8'h00;
    assign a_is_input  = in_mode0 && cur.mode_word[4];
    assign b_is_output = in_mode0 && !cur.mode_word[1];

    assign pa = cfg.base_port;
    assign pb = cfg.base_port + 16'd1;
    assign pc = cfg.base_port + 16'd2;
    assign pk = cfg.base_port + 16'd3;

    assign switch_nibble = cur.latch_b[3] ? cfg.dip_high : cfg.dip_low;
    assign bit_mask      = 8'h01 << item.write_data[3:1];
    assign kbd_enabled   = b_is_output &&
                           ((cur.latch_b & (B_CLK_ENABLE | B_KBD_CLEAR)) == B_CLK_ENABLE);

    always_comb
    begin
        c_view = 8'h00;
        if (in_mode0)
        begin
            if (!cur.mode_word[0])
                c_view = c_view | (cur.latch_c & NIBBLE_LOW);
            else
                c_view = c_view | {4'h0, switch_nibble};
            if (!cur.mode_word[3])
                c_view = c_view | (cur.latch_c & NIBBLE_HIGH);
            else
            begin
                if (cur.io_check_level)
                    c_view = c_view | C_IOCHK;
                if (cur.parity_level)
                    c_view = c_view | C_PARITY;
            end
        end
    end

    always_comb
    begin
        upd        = cur;
        rdata      = 8'h00;
        status     = ST_OK;
        released   = 1'b0;
        do_refresh = 1'b0;
        case (cmd_t'(item.command))
            CMD_READ:
            begin
                if (item.address == pa)
                    rdata = a_is_input ? (cur.key_ready ? cur.held_key : 8'h00) : cur.latch_a;
                else if (item.address == pb)
                    rdata = b_is_output ? cur.latch_b : 8'h00;
                else if (item.address == pc)
                    rdata = c_view;
                else if (item.address == pk)
                    status = ST_CTRL_READ;
                else
                    status = ST_BAD_ADDR;
            end
            CMD_WRITE:
            begin
                if (item.address == pa)
                    upd.latch_a = item.write_data;
                else if (item.address == pb)
                begin
                    upd.latch_b = item.write_data;
                    if ((item.write_data & B_KBD_CLEAR) != 8'h00)
                    begin
                        upd.key_ready = 1'b0;
                        released      = 1'b1;
                    end
                    do_refresh = 1'b1;
                end
                else if (item.address == pc)
                    upd.latch_c = item.write_data;
                else if (item.address == pk)
                begin
                    if ((item.write_data & MODE_FLAG) != 8'h00)
                        upd.mode_word = item.write_data;
                    else if (item.write_data[0])
                        upd.latch_c = cur.latch_c | bit_mask;
                    else
                        upd.latch_c = cur.latch_c & ~bit_mask;
                    do_refresh = 1'b1;
                end
                else
                    status = ST_BAD_ADDR;
            end
            CMD_FAULT:
            begin
                if (!item.fault_select)
                    upd.io_check_level = item.fault_level;
                else
                    upd.parity_level = item.fault_level;
                do_refresh = 1'b1;
            end
            default:
            begin
                if (cur.key_ready || !kbd_enabled)
                    status = ST_REFUSED;
                else
                begin
                    upd.held_key  = item.key_byte;
                    upd.key_ready = 1'b1;
                end
            end
        endcase
    end

    // nmi refresh looks at the state after the update
    assign nxt_b_out = ((upd.mode_word & MODE_NOT_ZERO) == 8'h00) && !upd.mode_word[1];
    assign pending   = nxt_b_out &&
                       ((upd.io_check_level && ((upd.latch_b & B_NO_IOCHK) == 8'h00)) ||
                        (upd.parity_level && ((upd.latch_b & B_NO_PARITY) == 8'h00)));

    always_comb
    begin
        nxt = upd;
        nmi = 1'b0;
        if (do_refresh)
        begin
            nxt.nmi_sent = pending;
            nmi          = pending && !upd.nmi_sent;
        end
    end

    always_comb
    begin
        res.read_data      = rdata;
        res.status         = status;
        res.irq_level      = nxt.key_ready;
        res.nmi_pulse      = nmi;
        res.speaker_gate   = nxt.latch_b[0];
        res.speaker_enable = nxt.latch_b[1];
        res.kbd_clock_held = !nxt.latch_b[6];
        res.kbd_clear      = nxt.latch_b[7];
        res.key_dropped    = released;
    end

endmodule

`default_nettype wire

>>> hdl/xt_ppi_keyboard_interface.sv
`default_nettype none
// a request is taken into the request register and moves on to the result register
// when that register is empty or its result is being accepted
// throughput: one request per cycle while result.ready stays high, set by the
// single-pass step logic between the request register and the result register
// reset: asynchronous active-low rst_n clears both stage valid bits, sets all ppi
// state and the configuration registers to their power-on values

module xt_ppi_keyboard_interface
    import xtppi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    xtppi_in_if.sink         request,
    xtppi_out_if.source      result
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      advance;
    logic      take;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || advance;
    assign take          = request.valid && request.ready;

    xtppi_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_port <= BASE_PORT_RESET;
            cfg_reg.dip_low   <= 4'h0;
            cfg_reg.dip_high  <= 4'h0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_PORT: cfg_reg.base_port <= cfg_data;
                CFG_DIP_LOW:   cfg_reg.dip_low   <= cfg_data[3:0];
                CFG_DIP_HIGH:  cfg_reg.dip_high  <= cfg_data[3:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.command      <= request.command;
            in_reg.address      <= request.address;
            in_reg.write_data   <= request.write_data;
            in_reg.fault_select <= request.fault_select;
            in_reg.fault_level  <= request.fault_level;
            in_reg.key_byte     <= request.key_byte;
        end
        if (advance)
            out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.read_data      = out_reg.read_data;
    assign result.status         = out_reg.status;
    assign result.irq_level      = out_reg.irq_level;
    assign result.nmi_pulse      = out_reg.nmi_pulse;
    assign result.speaker_gate   = out_reg.speaker_gate;
    assign result.speaker_enable = out_reg.speaker_enable;
    assign result.kbd_clock_held = out_reg.kbd_clock_held;
    assign result.kbd_clear      = out_reg.kbd_clear;
    assign result.key_dropped    = out_reg.key_dropped;

endmodule

`default_nettype wire

>>> tb/sv/xt_ppi_keyboard_interface_tb.sv
`default_nettype none

module xt_ppi_keyboard_interface_tb;
    import xtppi_pkg::*;

    localparam logic [7:0]  MODE_A_IN     = 8'h10;
    localparam logic [7:0]  MODE_B_IN     = 8'h02;
    localparam logic [7:0]  MODE_CL_IN    = 8'h01;
    localparam logic [7:0]  MODE_CH_IN    = 8'h08;
    localparam logic [7:0]  B_SWITCH_HIGH = 8'h08;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic        FAULT_IOCHK   = 1'b0;
    localparam logic        FAULT_PARITY  = 1'b1;
    localparam logic [15:0] PORT_A        = BASE_PORT_RESET;
    localparam logic [15:0] PORT_B        = BASE_PORT_RESET + 16'd1;
    localparam logic [15:0] PORT_C        = BASE_PORT_RESET + 16'd2;
    localparam logic [15:0] PORT_CTRL     = BASE_PORT_RESET + 16'd3;
    localparam int          RESULT_LATENCY  = 2;
    localparam int          PHASES          = 7;
    localparam int          ITEMS_PER_PHASE = 255;
    localparam int          SINK_HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT     = 2000;

    typedef struct packed {
        in_item_t  req;
        logic      fixed;
        out_item_t want;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    xtppi_in_if  request_ch ();
    xtppi_out_if result_ch ();

    xt_ppi_keyboard_interface dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    state_t      ppi;
    cfg_t        ppi_cfg;
    out_item_t   access_results[$];
    step_row_t   directed_steps[$];
    int          error_count = 0;
    int          stall_cycles = 0;
    logic        idle_on = 1'b1;
    logic        sink_hold = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic mode_zero();
        return (ppi.mode_word & MODE_NOT_ZERO) == 8'h00;
    endfunction

    function automatic logic port_b_out();
        return mode_zero() && (ppi.mode_word & MODE_B_IN) == 8'h00;
    endfunction

    function automatic logic nmi_update();
        logic pending;
        pending = port_b_out() &&
            ((ppi.io_check_level && (ppi.latch_b & B_NO_IOCHK) == 8'h00) ||
             (ppi.parity_level && (ppi.latch_b & B_NO_PARITY) == 8'h00));
        if (!pending)
        begin
            ppi.nmi_sent = 1'b0;
            return 1'b0;
        end
        if (!ppi.nmi_sent)
        begin
            ppi.nmi_sent = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_item_t ppi_access(input in_item_t r);
        out_item_t   o;
        logic [15:0] pa;
        logic [15:0] pb;
        logic [15:0] pc;
        logic [15:0] pk;
        logic [7:0]  view;
        o = '0;
        pa = ppi_cfg.base_port;
        pb = pa + 16'd1;
        pc = pa + 16'd2;
        pk = pa + 16'd3;
        case (cmd_t'(r.command))
            CMD_READ:
            begin
                if (r.address == pa)
                begin
                    if (mode_zero() && (ppi.mode_word & MODE_A_IN) != 8'h00)
                        o.read_data = ppi.key_ready ? ppi.held_key : 8'h00;
                    else
                        o.read_data = ppi.latch_a;
                end
                else if (r.address == pb)
                    o.read_data = port_b_out() ? ppi.latch_b : 8'h00;
                else if (r.address == pc)
                begin
                    view = 8'h00;
                    if (mode_zero())
                    begin
                        if ((ppi.mode_word & MODE_CL_IN) == 8'h00)
                            view = ppi.latch_c & NIBBLE_LOW;
                        else
                            view = {4'h0, ((ppi.latch_b & B_SWITCH_HIGH) != 8'h00) ?
                                    ppi_cfg.dip_high : ppi_cfg.dip_low};
                        if ((ppi.mode_word & MODE_CH_IN) == 8'h00)
                            view = view | (ppi.latch_c & NIBBLE_HIGH);
                        else
                        begin
                            if (ppi.io_check_level)
                                view = view | C_IOCHK;
                            if (ppi.parity_level)
                                view = view | C_PARITY;
                        end
                    end
                    o.read_data = view;
                end
                else if (r.address == pk)
                    o.status = ST_CTRL_READ;
                else
                    o.status = ST_BAD_ADDR;
            end
            CMD_WRITE:
            begin
                if (r.address == pa)
                    ppi.latch_a = r.write_data;
                else if (r.address == pb)
                begin
                    ppi.latch_b = r.write_data;
                    if ((r.write_data & B_KBD_CLEAR) != 8'h00)
                    begin
                        ppi.key_ready = 1'b0;
                        o.key_dropped = 1'b1;
                    end
                    o.nmi_pulse = nmi_update();
                end
                else if (r.address == pc)
                    ppi.latch_c = r.write_data;
                else if (r.address == pk)
                begin
                    if ((r.write_data & MODE_FLAG) != 8'h00)
                        ppi.mode_word = r.write_data;
                    else if (r.write_data[0])
                        ppi.latch_c = ppi.latch_c | (8'h01 << r.write_data[3:1]);
                    else
                        ppi.latch_c = ppi.latch_c & ~(8'h01 << r.write_data[3:1]);
                    o.nmi_pulse = nmi_update();
                end
                else
                    o.status = ST_BAD_ADDR;
            end
            CMD_FAULT:
            begin
                if (r.fault_select == FAULT_IOCHK)
                    ppi.io_check_level = r.fault_level;
                else
                    ppi.parity_level = r.fault_level;
                o.nmi_pulse = nmi_update();
            end
            CMD_KEY:
            begin
                if (ppi.key_ready || !(port_b_out() &&
                    (ppi.latch_b & (B_CLK_ENABLE | B_KBD_CLEAR)) == B_CLK_ENABLE))
                    o.status = ST_REFUSED;
                else
                begin
                    ppi.held_key = r.key_byte;
                    ppi.key_ready = 1'b1;
                end
            end
        endcase
        o.irq_level = ppi.key_ready;
        o.speaker_gate = ppi.latch_b[0];
        o.speaker_enable = ppi.latch_b[1];
        o.kbd_clock_held = (ppi.latch_b & B_CLK_ENABLE) == 8'h00;
        o.kbd_clear = (ppi.latch_b & B_KBD_CLEAR) != 8'h00;
        return o;
    endfunction

    function automatic in_item_t mk_req(input cmd_t c, input logic [15:0] a,
                                        input logic [7:0] d, input logic fs,
                                        input logic fl, input logic [7:0] k);
        in_item_t r;
        r.command = c;
        r.address = a;
        r.write_data = d;
        r.fault_select = fs;
        r.fault_level = fl;
        r.key_byte = k;
        return r;
    endfunction

    function automatic out_item_t reset_view(input logic [7:0] data, input logic [1:0] st);
        out_item_t o;
        o = '0;
        o.read_data = data;
        o.status = st;
        o.kbd_clock_held = 1'b1;
        return o;
    endfunction

    function automatic in_item_t rand_request();
        in_item_t    r;
        logic [15:0] pb;
        logic [15:0] pk;
        int          pick;
        int          knob;
        pick = $urandom_range(0, 99);
        knob = $urandom_range(0, 99);
        pb = ppi_cfg.base_port + 16'd1;
        pk = ppi_cfg.base_port + 16'd3;
        r.command = (pick < 25) ? CMD_READ : (pick < 70) ? CMD_WRITE :
                    (pick < 80) ? CMD_FAULT : CMD_KEY;
        r.address = (knob < 88) ? ppi_cfg.base_port + 16'($urandom_range(0, 3))
                                : 16'($urandom);
        r.write_data = 8'($urandom);
        r.fault_select = 1'($urandom);
        r.fault_level = 1'($urandom);
        r.key_byte = 8'($urandom);
        knob = $urandom_range(0, 99);
        // mostly mode 0 with port b out, and port b with the keyboard clock running
        if (r.address == pk)
        begin
            if (knob < 45)
                r.write_data = MODE_FLAG | (r.write_data & (MODE_A_IN | MODE_CH_IN | MODE_CL_IN));
            else if (knob < 55)
                r.write_data = r.write_data | MODE_FLAG;
            else
                r.write_data = r.write_data & ~MODE_FLAG;
        end
        else if (r.address == pb)
        begin
            if (knob < 60)
                r.write_data = (r.write_data & ~B_KBD_CLEAR) | B_CLK_ENABLE;
            else if (knob < 80)
                r.write_data = r.write_data | B_KBD_CLEAR;
        end
        return r;
    endfunction

    task automatic add_step(input in_item_t r, input logic fixed, input out_item_t want);
        step_row_t row;
        row.req = r;
        row.fixed = fixed;
        row.want = want;
        directed_steps.push_back(row);
    endtask

    task automatic send_request(input in_item_t r, input logic fixed, input out_item_t want);
        out_item_t guess;
        request_ch.valid <= 1'b1;
        request_ch.command <= r.command;
        request_ch.address <= r.address;
        request_ch.write_data <= r.write_data;
        request_ch.fault_select <= r.fault_select;
        request_ch.fault_level <= r.fault_level;
        request_ch.key_byte <= r.key_byte;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        guess = ppi_access(r);
        access_results.push_back(fixed ? want : guess);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain();
        request_ch.valid <= 1'b0;
        while (access_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_BASE_PORT: ppi_cfg.base_port = val;
            CFG_DIP_LOW:   ppi_cfg.dip_low = val[3:0];
            CFG_DIP_HIGH:  ppi_cfg.dip_high = val[3:0];
            default:       ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (access_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = access_results.pop_front();
                check_field("read_data", want.read_data, result_ch.read_data);
                check_field("status", 8'(want.status), 8'(result_ch.status));
                check_field("irq_level", 8'(want.irq_level), 8'(result_ch.irq_level));
                check_field("nmi_pulse", 8'(want.nmi_pulse), 8'(result_ch.nmi_pulse));
                check_field("speaker_gate", 8'(want.speaker_gate),
                            8'(result_ch.speaker_gate));
                check_field("speaker_enable", 8'(want.speaker_enable),
                            8'(result_ch.speaker_enable));
                check_field("kbd_clock_held", 8'(want.kbd_clock_held),
                            8'(result_ch.kbd_clock_held));
                check_field("kbd_clear", 8'(want.kbd_clear), 8'(result_ch.kbd_clear));
                check_field("key_dropped", 8'(want.key_dropped),
                            8'(result_ch.key_dropped));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("xt_ppi_keyboard_interface_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int          phase;
        int          n;
        logic [15:0] base_val;
        logic [15:0] lo_val;
        logic [15:0] hi_val;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_BASE_PORT;
        cfg_data <= 16'h0000;
        request_ch.valid <= 1'b0;
        request_ch.command <= CMD_READ;
        request_ch.address <= 16'h0000;
        request_ch.write_data <= 8'h00;
        request_ch.fault_select <= 1'b0;
        request_ch.fault_level <= 1'b0;
        request_ch.key_byte <= 8'h00;

        ppi = '0;
        ppi.mode_word = MODE_RESET;
        ppi_cfg.base_port = BASE_PORT_RESET;
        ppi_cfg.dip_low = 4'h0;
        ppi_cfg.dip_high = 4'h0;

        add_step(mk_req(CMD_READ, PORT_A, 8'h00, 1'b0, 1'b0, 8'h00), 1'b1,
                 reset_view(8'h00, ST_OK));
        add_step(mk_req(CMD_READ, PORT_B, 8'h00, 1'b0, 1'b0, 8'h00), 1'b1,
                 reset_view(8'h00, ST_OK));
        add_step(mk_req(CMD_READ, PORT_C, 8'h00, 1'b0, 1'b0, 8'h00), 1'b1,
                 reset_view(8'h00, ST_OK));
        add_step(mk_req(CMD_READ, PORT_CTRL, 8'h00, 1'b0, 1'b0, 8'h00), 1'b1,
                 reset_view(8'h00, ST_CTRL_READ));
        add_step(mk_req(CMD_READ, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00), 1'b1,
                 reset_view(8'h00, ST_BAD_ADDR));
        add_step(mk_req(CMD_WRITE, 16'hffff, 8'hff, 1'b1, 1'b1, 8'hff), 1'b1,
                 reset_view(8'h00, ST_BAD_ADDR));
        add_step(mk_req(CMD_KEY, PORT_A, 8'h00, 1'b0, 1'b0, 8'h5a), 1'b1,
                 reset_view(8'h00, ST_REFUSED));
        // mode 0, port b out, then the keyboard clock enabled
        add_step(mk_req(CMD_WRITE, PORT_CTRL, 8'h99, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_WRITE, PORT_B, 8'h40, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_KEY, PORT_A, 8'h00, 1'b0, 1'b0, 8'hff), 1'b0, '0);
        add_step(mk_req(CMD_KEY, PORT_A, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_READ, PORT_A, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_FAULT, PORT_A, 8'h00, FAULT_IOCHK, 1'b1, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_FAULT, PORT_A, 8'h00, FAULT_PARITY, 1'b1, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_READ, PORT_C, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_WRITE, PORT_B, 8'hf0, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        // clear with no byte held
        add_step(mk_req(CMD_WRITE, PORT_B, 8'h80, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_WRITE, PORT_CTRL, 8'h0f, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_WRITE, PORT_CTRL, 8'h80, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_READ, PORT_C, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_WRITE, PORT_A, 8'ha5, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_READ, PORT_A, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        // leave mode 0
        add_step(mk_req(CMD_WRITE, PORT_CTRL, 8'he4, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_READ, PORT_B, 8'h00, 1'b0, 1'b0, 8'h00), 1'b0, '0);
        add_step(mk_req(CMD_KEY, PORT_A, 8'h00, 1'b0, 1'b0, 8'h11), 1'b0, '0);
        add_step(mk_req(CMD_FAULT, PORT_A, 8'h00, FAULT_IOCHK, 1'b0, 8'h00), 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            send_request(directed_steps[i].req, directed_steps[i].fixed,
                         directed_steps[i].want);
            sender_gap();
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    base_val = 16'h0000;
                    lo_val = 16'h0000;
                    hi_val = 16'h000f;
                end
                1:
                begin
                    base_val = 16'hfffc;
                    lo_val = 16'h000f;
                    hi_val = 16'h0000;
                end
                3:
                begin
                    // port c and control wrap past the top of the address space
                    base_val = 16'hfffe;
                    lo_val = 16'($urandom);
                    hi_val = 16'($urandom);
                end
                PHASES - 1:
                begin
                    base_val = BASE_PORT_RESET;
                    lo_val = 16'($urandom);
                    hi_val = 16'($urandom);
                end
                default:
                begin
                    base_val = 16'($urandom_range(0, 16'hfffc));
                    lo_val = 16'($urandom);
                    hi_val = 16'($urandom);
                end
            endcase
            write_reg(CFG_BASE_PORT, base_val);
            write_reg(CFG_DIP_LOW, lo_val);
            write_reg(CFG_DIP_HIGH, hi_val);
            if (phase == 2)
                write_reg(CFG_UNUSED, 16'($urandom));
            cfg_we <= 1'b0;
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == 40)
                    sink_hold = 1'b1;
                send_request(rand_request(), 1'b0, '0);
                if (phase == 2 && n == 100)
                    drain();
                else
                    sender_gap();
            end
        end

        drain();
        if (error_count == 0)
            $display("xt_ppi_keyboard_interface_tb: done, clean");
        else
            $display("xt_ppi_keyboard_interface_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
